>>> hw/rtl/usbc_pkg.sv
package usbc_pkg;

  localparam int BULK_MAX_PACKET    = 512;
  localparam int CONTROL_MAX_PACKET = 64;

  localparam logic [15:0] BULK_MPS = 16'(BULK_MAX_PACKET);
  localparam logic [7:0]  CTRL_MPS = 8'(CONTROL_MAX_PACKET);

  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  localparam logic [7:0] DT_DEVICE    = 8'd1;
  localparam logic [7:0] DT_CONFIG    = 8'd2;
  localparam logic [7:0] DT_STRING    = 8'd3;
  localparam logic [7:0] DT_INTERFACE = 8'd4;
  localparam logic [7:0] DT_ENDPOINT  = 8'd5;

  localparam logic [7:0] STR_LANG = 8'h00;
  localparam logic [7:0] STR_MFR  = 8'h40;
  localparam logic [7:0] STR_PROD = 8'h41;
  localparam logic [7:0] STR_SER  = 8'h42;
  localparam logic [7:0] STR_IFC  = 8'h43;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_ID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_RELEASE = 2'd2;

  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_DEVICE,
    SRC_CFG_SHORT,
    SRC_CFG_FULL,
    SRC_LANG,
    SRC_MFR,
    SRC_PROD,
    SRC_SER,
    SRC_IFC,
    SRC_FALLBACK,
    SRC_IFACE,
    SRC_EP_IN,
    SRC_EP_OUT,
    SRC_STATUS
  } usbc_src_t;

  typedef struct packed {
    logic        func;
    logic        setup_ready;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic        ep1_halted;
    logic        out_buffer_full;
    logic        in_transfer_ready;
  } usbc_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        last;
    logic        serviced;
    logic        in_packet_ready;
    logic        data_end;
    logic        address_valid;
    logic [6:0]  device_address;
    logic        configure_ep1;
    logic        clear_halt_ep1;
    logic [15:0] configuration_value;
  } usbc_resp_t;

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] device_release;
  } usbc_ids_t;

  typedef struct packed {
    usbc_src_t   src;
    logic        status_bit;
    logic        serviced;
    logic        pkt;
    logic        dend;
    logic        addr_v;
    logic [6:0]  addr;
    logic        cfg_ep;
    logic        clr;
    logic [15:0] config_val;
  } usbc_cmd_t;

endpackage

>>> hw/rtl/usb_control_request_responder.sv
// Endpoint-zero control request responder. Each input beat (bus reset or
// endpoint-zero event with a decoded setup packet) yields zero to 32
// descriptor/status data beats followed by exactly one handshake beat
// (kind=1, last=1) carrying the control flags; configuration_value on every
// beat is the configuration after that request. A request is classified
// combinationally and queued (two deep); the back end emits one beat per
// cycle while not stalled, with an idle state between requests. The
// vendor, product and release registers must be written only while idle.
module usb_control_request_responder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  usbc_pkg::usbc_req_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output usbc_pkg::usbc_resp_t            out_data,
  input  logic                            cfg_we,
  input  logic [usbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import usbc_pkg::*;

  usbc_ids_t ids_r;
  logic      q_full, q_push, q_pop, q_valid;
  usbc_cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r.vendor_id      <= 16'hf055;
      ids_r.product_id     <= 16'h1337;
      ids_r.device_release <= 16'h0100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VENDOR_ID:      ids_r.vendor_id      <= cfg_wdata;
        CFG_PRODUCT_ID:     ids_r.product_id     <= cfg_wdata;
        CFG_DEVICE_RELEASE: ids_r.device_release <= cfg_wdata;
        default:            ids_r                <= ids_r;
      endcase
    end
  end

  usbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  usbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  usbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ids       (ids_r),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/usbc_front.sv
module usbc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  usbc_pkg::usbc_req_t in_data,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output usbc_pkg::usbc_cmd_t q_cmd
);
  import usbc_pkg::*;

  logic        awaiting_r, awaiting_nxt;
  logic [15:0] config_r, config_nxt;
  usbc_cmd_t   cmd;
  logic [7:0]  dtype, dindex;
  logic        status_bit;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign dtype    = in_data.request_value[15:8];
  assign dindex   = in_data.request_value[7:0];

  always_comb begin
    status_bit = 1'b0;
    if (in_data.request_index == 16'd1) begin
      if (in_data.request_value == 16'd0) begin
        status_bit = in_data.ep1_halted;
      end else if (in_data.request_value == 16'd1) begin
        status_bit = in_data.out_buffer_full;
      end
    end else if (in_data.request_index == 16'd2 && in_data.request_value == 16'd2) begin
      status_bit = in_data.in_transfer_ready;
    end
  end

  always_comb begin
    awaiting_nxt = awaiting_r;
    config_nxt   = config_r;
    cmd          = '0;
    cmd.src      = SRC_NONE;
    priority if (in_data.func) begin
      awaiting_nxt = 1'b0;
    end else if (awaiting_r) begin
      awaiting_nxt = 1'b0;
    end else if (in_data.setup_ready) begin
      unique case (in_data.request_code)
        REQ_GET_DESCRIPTOR: begin
          cmd.serviced = 1'b1;
          cmd.pkt      = 1'b1;
          cmd.dend     = 1'b1;
          awaiting_nxt = 1'b1;
          unique case (dtype)
            DT_DEVICE:    cmd.src = SRC_DEVICE;
            DT_CONFIG:    cmd.src = (in_data.request_length > 16'd9) ? SRC_CFG_FULL
                                                                      : SRC_CFG_SHORT;
            DT_STRING: begin
              unique case (dindex)
                STR_LANG: cmd.src = SRC_LANG;
                STR_MFR:  cmd.src = SRC_MFR;
                STR_PROD: cmd.src = SRC_PROD;
                STR_SER:  cmd.src = SRC_SER;
                STR_IFC:  cmd.src = SRC_IFC;
                default:  cmd.src = SRC_FALLBACK;
              endcase
            end
            DT_INTERFACE: cmd.src = SRC_IFACE;
            DT_ENDPOINT:  cmd.src = (dindex == 8'd0) ? SRC_EP_IN : SRC_EP_OUT;
            default:      cmd.src = SRC_NONE;
          endcase
        end
        REQ_SET_ADDRESS: begin
          cmd.serviced = 1'b1;
          cmd.dend     = 1'b1;
          cmd.addr_v   = 1'b1;
          cmd.addr     = in_data.request_value[6:0];
          awaiting_nxt = 1'b1;
        end
        REQ_SET_CONFIGURATION: begin
          cmd.serviced = 1'b1;
          cmd.dend     = 1'b1;
          cmd.cfg_ep   = 1'b1;
          config_nxt   = in_data.request_value;
          awaiting_nxt = 1'b1;
        end
        REQ_GET_STATUS: begin
          cmd.serviced   = 1'b1;
          cmd.pkt        = 1'b1;
          cmd.dend       = 1'b1;
          cmd.src        = SRC_STATUS;
          cmd.status_bit = status_bit;
          awaiting_nxt   = 1'b1;
        end
        REQ_CLEAR_FEATURE: begin
          cmd.serviced = 1'b1;
          cmd.dend     = 1'b1;
          cmd.clr      = (in_data.request_index == 16'd1) && (in_data.request_value == 16'd0);
          awaiting_nxt = 1'b0;
        end
        default: begin
          awaiting_nxt = 1'b0;
        end
      endcase
    end
    cmd.config_val = config_nxt;
  end

  assign q_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      config_r   <= '0;
    end else if (q_push) begin
      awaiting_r <= awaiting_nxt;
      config_r   <= config_nxt;
    end
  end

endmodule

>>> hw/rtl/usbc_queue.sv
module usbc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  usbc_pkg::usbc_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output usbc_pkg::usbc_cmd_t head
);
  import usbc_pkg::*;

  localparam int DEPTH = 2;

  usbc_cmd_t  slot_r [DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/usbc_back.sv
module usbc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  usbc_pkg::usbc_ids_t  ids,
  input  logic                 q_valid,
  input  usbc_pkg::usbc_cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output usbc_pkg::usbc_resp_t out_data
);
  import usbc_pkg::*;

  localparam logic [7:0] CFG_ROM   [9] = '{8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00,
                                           8'hc0, 8'h01};
  localparam logic [7:0] IFACE_ROM [9] = '{8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'h00,
                                           8'h00, 8'h43};
  localparam logic [7:0] LANG_ROM  [4] = '{8'h04, 8'h03, 8'h09, 8'h04};
  localparam logic [7:0] MFR_CHARS [8] = '{8'h49, 8'h6e, 8'h66, 8'h65, 8'h72, 8'h6e, 8'h6f,
                                           8'h00};
  localparam logic [7:0] PROD_CHARS[8] = '{8'h4e, 8'h61, 8'h6e, 8'h6f, 8'h4e, 8'h6f, 8'h74,
                                           8'h65};
  localparam logic [7:0] SER_CHARS [8] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h00, 8'h00, 8'h00,
                                           8'h00};
  localparam logic [7:0] IFC_CHARS [8] = '{8'h43, 8'h75, 8'h73, 8'h74, 8'h6f, 8'h6d, 8'h00,
                                           8'h00};

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  function automatic logic [5:0] src_len(usbc_src_t s);
    logic [5:0] n;
    unique case (s)
      SRC_DEVICE:    n = 6'd18;
      SRC_CFG_SHORT: n = 6'd9;
      SRC_CFG_FULL:  n = 6'd32;
      SRC_LANG:      n = 6'd4;
      SRC_MFR:       n = 6'd16;
      SRC_PROD:      n = 6'd18;
      SRC_SER:       n = 6'd10;
      SRC_IFC:       n = 6'd14;
      SRC_FALLBACK:  n = 6'd2;
      SRC_IFACE:     n = 6'd9;
      SRC_EP_IN:     n = 6'd7;
      SRC_EP_OUT:    n = 6'd7;
      SRC_STATUS:    n = 6'd2;
      default:       n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ep_byte(logic in_dir, logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = 8'h07;
      3'd1:    b = 8'h05;
      3'd2:    b = in_dir ? 8'h81 : 8'h01;
      3'd3:    b = 8'h02;
      3'd4:    b = BULK_MPS[7:0];
      3'd5:    b = BULK_MPS[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] str_byte(logic [7:0] chr, logic [4:0] i, logic [7:0] len);
    logic [7:0] b;
    priority if (i == 5'd0) begin
      b = len;
    end else if (i == 5'd1) begin
      b = 8'h03;
    end else if (i[0]) begin
      b = 8'h00;
    end else begin
      b = chr;
    end
    return b;
  endfunction

  function automatic logic [7:0] dev_byte(usbc_ids_t d, logic [4:0] i);
    logic [7:0] b;
    unique case (i)
      5'd0:    b = 8'h12;
      5'd1:    b = 8'h01;
      5'd3:    b = 8'h02;
      5'd4:    b = 8'hff;
      5'd7:    b = CTRL_MPS;
      5'd8:    b = d.vendor_id[7:0];
      5'd9:    b = d.vendor_id[15:8];
      5'd10:   b = d.product_id[7:0];
      5'd11:   b = d.product_id[15:8];
      5'd12:   b = d.device_release[7:0];
      5'd13:   b = d.device_release[15:8];
      5'd14:   b = 8'h40;
      5'd15:   b = 8'h41;
      5'd16:   b = 8'h42;
      5'd17:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  state_t     state_r;
  usbc_cmd_t  cmd_r;
  logic [5:0] idx_r;
  logic       out_valid_r;
  usbc_resp_t out_data_r;

  logic [4:0] bi;
  logic [2:0] ci;
  logic [5:0] cur_len;
  logic       more;
  logic       load;
  logic [7:0] byte_val;
  usbc_resp_t item;

  assign bi      = idx_r[4:0];
  assign ci      = 3'(bi[4:1] - 4'd1);
  assign cur_len = src_len(cmd_r.src);
  assign more    = idx_r < cur_len;
  assign load    = !out_valid_r || !out_stall;
  assign q_pop   = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    unique case (cmd_r.src)
      SRC_DEVICE:    byte_val = dev_byte(ids, bi);
      SRC_CFG_SHORT: byte_val = CFG_ROM[bi[3:0]];
      SRC_CFG_FULL: begin
        priority if (bi < 5'd9) begin
          byte_val = CFG_ROM[bi[3:0]];
        end else if (bi < 5'd18) begin
          byte_val = IFACE_ROM[4'(bi - 5'd9)];
        end else if (bi < 5'd25) begin
          byte_val = ep_byte(1'b1, 3'(bi - 5'd18));
        end else begin
          byte_val = ep_byte(1'b0, 3'(bi - 5'd25));
        end
      end
      SRC_LANG:      byte_val = LANG_ROM[bi[1:0]];
      SRC_MFR:       byte_val = str_byte(MFR_CHARS[ci], bi, 8'd16);
      SRC_PROD:      byte_val = str_byte(PROD_CHARS[ci], bi, 8'd18);
      SRC_SER:       byte_val = str_byte(SER_CHARS[ci], bi, 8'd10);
      SRC_IFC:       byte_val = str_byte(IFC_CHARS[ci], bi, 8'd14);
      SRC_FALLBACK:  byte_val = bi[0] ? 8'h03 : 8'h02;
      SRC_IFACE:     byte_val = IFACE_ROM[bi[3:0]];
      SRC_EP_IN:     byte_val = ep_byte(1'b1, bi[2:0]);
      SRC_EP_OUT:    byte_val = ep_byte(1'b0, bi[2:0]);
      SRC_STATUS:    byte_val = bi[0] ? 8'h00 : {7'd0, cmd_r.status_bit};
      default:       byte_val = 8'h00;
    endcase
  end

  always_comb begin
    item                     = '0;
    item.configuration_value = cmd_r.config_val;
    if (more) begin
      item.data_byte = byte_val;
    end else begin
      item.kind            = 1'b1;
      item.last            = 1'b1;
      item.serviced        = cmd_r.serviced;
      item.in_packet_ready = cmd_r.pkt;
      item.data_end        = cmd_r.dend;
      item.address_valid   = cmd_r.addr_v;
      item.device_address  = cmd_r.addr;
      item.configure_ep1   = cmd_r.cfg_ep;
      item.clear_halt_ep1  = cmd_r.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
      idx_r       <= 6'd0;
    end else begin
      if (state_r == ST_IDLE && out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            idx_r   <= 6'd0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (load) begin
            out_valid_r <= 1'b1;
            out_data_r  <= item;
            if (more) begin
              idx_r <= idx_r + 6'd1;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/usbc_checker.sv
module usbc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input usbc_pkg::usbc_resp_t out_data
);
  import usbc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_data_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kind |-> !out_data.last && !out_data.serviced &&
      !out_data.in_packet_ready && !out_data.data_end && !out_data.address_valid &&
      !out_data.configure_ep1 && !out_data.clear_halt_ep1)
    else $error("data beat carries handshake flags");

  a_handshake_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> out_data.last && out_data.data_byte == 8'h00)
    else $error("malformed handshake beat");

  a_addr_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.address_valid |-> out_data.device_address == 7'd0)
    else $error("address without address_valid");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.address_valid || out_data.configure_ep1 ||
      out_data.clear_halt_ep1 || out_data.in_packet_ready)
      |-> out_data.serviced && out_data.data_end)
    else $error("request flag without serviced/data_end");

endmodule

bind usb_control_request_responder usbc_checker u_usbc_checker (.*);

>>> test/tb_usb_control_request_responder.sv
module tb_usb_control_request_responder;
  timeunit 1ns;
  timeprecision 1ps;
  import usbc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 63;

  localparam logic [71:0] CONFIG_DESC   = 72'h09_02_20_00_01_01_00_c0_01;
  localparam logic [71:0] IFACE_DESC    = 72'h09_04_00_00_02_ff_00_00_43;
  localparam logic [31:0] LANG_DESC     = 32'h04_03_09_04;
  localparam logic [15:0] FALLBACK_DESC = 16'h02_03;
  localparam logic [55:0] MFR_CHARS     = 56'h49_6e_66_65_72_6e_6f;
  localparam logic [63:0] PROD_CHARS    = 64'h4e_61_6e_6f_4e_6f_74_65;
  localparam logic [31:0] SER_CHARS     = 32'h31_32_33_34;
  localparam logic [47:0] IFC_CHARS     = 48'h43_75_73_74_6f_6d;

  typedef struct {
    usbc_req_t  req;
    bit         typed;
    usbc_resp_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  usbc_req_t            in_data;
  logic                 out_valid;
  logic                 out_stall;
  usbc_resp_t           out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  // predictor state
  logic        awaiting_ack;
  logic [15:0] config_value;
  logic [15:0] vid_reg, pid_reg, rel_reg;

  usbc_resp_t step_beats[$];
  usbc_resp_t expected_beats[$];
  dir_row_t   dir_rows[$];
  int         error_count = 0;
  int         send_idle = 0;
  int         recv_stall = 0;

  usb_control_request_responder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic add_byte(input logic [7:0] b);
    usbc_resp_t beat;
    beat = '0;
    beat.data_byte = b;
    beat.configuration_value = config_value;
    step_beats.push_back(beat);
  endtask

  // first byte sits in the most significant of the n low bytes
  task automatic add_bytes(input logic [143:0] v, input int n);
    for (int i = 0; i < n; i++) add_byte(v[8*(n-1-i) +: 8]);
  endtask

  task automatic add_string(input logic [63:0] v, input int n);
    add_byte(8'(2 + 2 * n));
    add_byte(8'h03);
    for (int i = 0; i < n; i++) begin
      add_byte(v[8*(n-1-i) +: 8]);
      add_byte(8'h00);
    end
  endtask

  function automatic logic [55:0] endpoint_desc(input bit in_dir);
    return {8'h07, 8'h05, in_dir ? 8'h81 : 8'h01, 8'h02, BULK_MPS[7:0], BULK_MPS[15:8], 8'h00};
  endfunction

  task automatic compute_response(input usbc_req_t r);
    usbc_resp_t  hs;
    logic [7:0]  dtype, didx;
    logic        status_bit;
    step_beats.delete();
    hs = '0;
    hs.kind = 1'b1;
    hs.last = 1'b1;
    dtype = r.request_value[15:8];
    didx = r.request_value[7:0];
    if (r.func || awaiting_ack) begin
      awaiting_ack = 1'b0;
    end else if (r.setup_ready) begin
      case (r.request_code)
        REQ_GET_DESCRIPTOR: begin
          hs.serviced = 1'b1;
          hs.in_packet_ready = 1'b1;
          hs.data_end = 1'b1;
          awaiting_ack = 1'b1;
          case (dtype)
            DT_DEVICE: add_bytes({8'h12, 8'h01, 8'h00, 8'h02, 8'hff, 8'h00, 8'h00, CTRL_MPS,
                                  vid_reg[7:0], vid_reg[15:8], pid_reg[7:0], pid_reg[15:8],
                                  rel_reg[7:0], rel_reg[15:8], 8'h40, 8'h41, 8'h42, 8'h01},
                                 18);
            DT_CONFIG: begin
              add_bytes(CONFIG_DESC, 9);
              if (r.request_length > 16'd9) begin
                add_bytes(IFACE_DESC, 9);
                add_bytes(endpoint_desc(1'b1), 7);
                add_bytes(endpoint_desc(1'b0), 7);
              end
            end
            DT_STRING: begin
              case (didx)
                STR_LANG: add_bytes(LANG_DESC, 4);
                STR_MFR:  add_string(MFR_CHARS, 7);
                STR_PROD: add_string(PROD_CHARS, 8);
                STR_SER:  add_string(SER_CHARS, 4);
                STR_IFC:  add_string(IFC_CHARS, 6);
                default:  add_bytes(FALLBACK_DESC, 2);
              endcase
            end
            DT_INTERFACE: add_bytes(IFACE_DESC, 9);
            DT_ENDPOINT:  add_bytes(endpoint_desc(didx == 8'h00), 7);
            default: ;
          endcase
        end
        REQ_SET_ADDRESS: begin
          hs.serviced = 1'b1;
          hs.data_end = 1'b1;
          hs.address_valid = 1'b1;
          hs.device_address = r.request_value[6:0];
          awaiting_ack = 1'b1;
        end
        REQ_SET_CONFIGURATION: begin
          hs.serviced = 1'b1;
          hs.data_end = 1'b1;
          hs.configure_ep1 = 1'b1;
          config_value = r.request_value;
          awaiting_ack = 1'b1;
        end
        REQ_GET_STATUS: begin
          status_bit = 1'b0;
          if (r.request_index == 16'd1) begin
            if (r.request_value == 16'd0) status_bit = r.ep1_halted;
            else if (r.request_value == 16'd1) status_bit = r.out_buffer_full;
          end else if (r.request_index == 16'd2 && r.request_value == 16'd2) begin
            status_bit = r.in_transfer_ready;
          end
          add_byte({7'd0, status_bit});
          add_byte(8'h00);
          hs.serviced = 1'b1;
          hs.in_packet_ready = 1'b1;
          hs.data_end = 1'b1;
          awaiting_ack = 1'b1;
        end
        REQ_CLEAR_FEATURE: begin
          hs.serviced = 1'b1;
          hs.data_end = 1'b1;
          hs.clear_halt_ep1 = (r.request_index == 16'd1 && r.request_value == 16'd0);
          awaiting_ack = 1'b0;
        end
        default: awaiting_ack = 1'b0;
      endcase
    end
    hs.configuration_value = config_value;
    step_beats.push_back(hs);
  endtask

  function automatic usbc_req_t mk_req(input bit func, input bit ready, input logic [7:0] code,
                                       input logic [15:0] value, index, length,
                                       input logic [2:0] flags);
    usbc_req_t r;
    r.func = func;
    r.setup_ready = ready;
    r.request_code = code;
    r.request_value = value;
    r.request_index = index;
    r.request_length = length;
    {r.ep1_halted, r.out_buffer_full, r.in_transfer_ready} = flags;
    return r;
  endfunction

  function automatic usbc_resp_t handshake(input bit srv, pkt, dend, addr_v,
                                           input logic [6:0] addr, input bit clr);
    usbc_resp_t h;
    h = '0;
    h.kind = 1'b1;
    h.last = 1'b1;
    h.serviced = srv;
    h.in_packet_ready = pkt;
    h.data_end = dend;
    h.address_valid = addr_v;
    h.device_address = addr;
    h.clear_halt_ep1 = clr;
    return h;
  endfunction

  function automatic usbc_req_t random_request();
    usbc_req_t  r;
    logic [7:0] dtype, didx;
    r = mk_req(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 3'($urandom_range(7)));
    if ($urandom_range(99) < 85) begin
      r.func = ($urandom_range(15) == 0);
      r.setup_ready = ($urandom_range(15) != 0);
      case ($urandom_range(7))
        0: begin
          r.request_code = REQ_GET_STATUS;
          if ($urandom_range(3) != 0) r.request_index = 16'($urandom_range(1, 2));
          if ($urandom_range(3) != 0) r.request_value = 16'($urandom_range(2));
        end
        1: begin
          r.request_code = REQ_CLEAR_FEATURE;
          if ($urandom_range(3) != 0) r.request_index = 16'd1;
          if ($urandom_range(3) != 0) r.request_value = 16'd0;
        end
        2: r.request_code = REQ_SET_ADDRESS;
        3: begin
          r.request_code = REQ_SET_CONFIGURATION;
          if ($urandom_range(1)) r.request_value = 16'($urandom_range(3));
        end
        default: begin
          r.request_code = REQ_GET_DESCRIPTOR;
          dtype = 8'($urandom_range(6));
          didx = r.request_value[7:0];
          if (dtype == DT_STRING && $urandom_range(3) != 0)
            didx = ($urandom_range(4) == 0) ? STR_LANG : 8'(STR_MFR + $urandom_range(4));
          if (dtype == DT_ENDPOINT && $urandom_range(1)) didx = 8'h00;
          r.request_value = {dtype, didx};
          if ($urandom_range(1)) r.request_length = 16'($urandom_range(12));
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input usbc_req_t r, input bit typed, input usbc_resp_t want);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    compute_response(r);
    if (typed) expected_beats.push_back(want);
    else foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      CFG_VENDOR_ID:      vid_reg = d;
      CFG_PRODUCT_ID:     pid_reg = d;
      CFG_DEVICE_RELEASE: rel_reg = d;
      default: ;
    endcase
  endtask

  task automatic program_ids(input logic [15:0] v, p, rel, input bit poke_unused);
    wait_drained();
    write_reg(CFG_VENDOR_ID, v);
    write_reg(CFG_PRODUCT_ID, p);
    write_reg(CFG_DEVICE_RELEASE, rel);
    if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // result side: random stall, compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    usbc_resp_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat 0x%0h", out_data);
        error_count++;
      end else begin
        w = expected_beats.pop_front();
        check_field("kind", w.kind, out_data.kind);
        check_field("data_byte", w.data_byte, out_data.data_byte);
        check_field("last", w.last, out_data.last);
        check_field("serviced", w.serviced, out_data.serviced);
        check_field("in_packet_ready", w.in_packet_ready, out_data.in_packet_ready);
        check_field("data_end", w.data_end, out_data.data_end);
        check_field("address_valid", w.address_valid, out_data.address_valid);
        check_field("device_address", w.device_address, out_data.device_address);
        check_field("configure_ep1", w.configure_ep1, out_data.configure_ep1);
        check_field("clear_halt_ep1", w.clear_halt_ep1, out_data.clear_halt_ep1);
        check_field("configuration_value", w.configuration_value,
                    out_data.configuration_value);
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  initial begin
    #20_000_000;
    $display("usb_control_request_responder test failed");
    $finish;
  end

  initial begin
    usbc_req_t  ack_req;
    usbc_resp_t idle_hs;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    awaiting_ack = 1'b0;
    config_value = '0;
    vid_reg = 16'hf055;
    pid_reg = 16'h1337;
    rel_reg = 16'h0100;

    // swallowed while a status stage is awaited
    ack_req = mk_req(0, 1, REQ_SET_CONFIGURATION, 16'h1234, 16'h0, 16'h0, 3'b000);
    idle_hs = handshake(0, 0, 0, 0, 7'h00, 0);

    dir_rows.push_back('{mk_req(1, 1, REQ_GET_DESCRIPTOR, 16'hffff, 16'hffff, 16'hffff,
                                3'b111), 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 0, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0, 16'h12, 3'b000),
                         1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, 8'hff, 16'hffff, 16'hffff, 16'hffff, 3'b111),
                         1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_CLEAR_FEATURE, 16'h0000, 16'h0001, 16'h0, 3'b100),
                         1'b1, handshake(1, 0, 1, 0, 7'h00, 1)});
    dir_rows.push_back('{mk_req(0, 1, REQ_SET_ADDRESS, 16'hffff, 16'h0, 16'h0, 3'b000),
                         1'b1, handshake(1, 0, 1, 1, 7'h7f, 0)});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0, 16'h40, 3'b000),
                         1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_SET_ADDRESS, 16'h0000, 16'h0, 16'h0, 3'b000),
                         1'b1, handshake(1, 0, 1, 1, 7'h00, 0)});
    dir_rows.push_back('{mk_req(1, 0, 8'h00, 16'h0, 16'h0, 16'h0, 3'b000), 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0, 16'h12, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0200, 16'h0, 16'd9, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{mk_req(1, 1, 8'h00, 16'h0, 16'h0, 16'h0, 3'b000), 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0200, 16'h0, 16'd10, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0340, 16'h0409, 16'hff, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0344, 16'h0409, 16'hff, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0400, 16'h0, 16'd9, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h05ff, 16'h0, 16'd7, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_DESCRIPTOR, 16'h0000, 16'h0, 16'hffff, 3'b000),
                         1'b1, handshake(1, 1, 1, 0, 7'h00, 0)});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_GET_STATUS, 16'h0000, 16'h0001, 16'd2, 3'b100),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b1, idle_hs});
    dir_rows.push_back('{mk_req(0, 1, REQ_SET_CONFIGURATION, 16'hffff, 16'h0, 16'h0, 3'b000),
                         1'b0, idle_hs});
    dir_rows.push_back('{ack_req, 1'b0, idle_hs});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: program_ids(16'h0000, 16'h0000, 16'h0000, 1'b0);
        1: program_ids(16'hffff, 16'hffff, 16'hffff, 1'b0);
        default: program_ids(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), phase == 2);
      endcase
      send_idle  = (phase == 1) ? 84 : (phase == 3) ? 37 : 0;
      recv_stall = (phase == 2) ? 84 : (phase == 3) ? 37 : 0;
      repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, idle_hs);
    end

    wait_drained();
    if (error_count == 0) $display("usb_control_request_responder test passed");
    else $display("usb_control_request_responder test failed");
    $finish;
  end

endmodule

>>> usb_control_request_responder.f
hw/rtl/usbc_pkg.sv
hw/rtl/usbc_front.sv
hw/rtl/usbc_queue.sv
hw/rtl/usbc_back.sv
hw/rtl/usb_control_request_responder.sv
hw/rtl/usbc_checker.sv
test/tb_usb_control_request_responder.sv
